// File: rtl/yrfi_pkg.sv
`timescale 1ns / 1ps

package yrfi_pkg;

	localparam int TAP_COUNT_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd3;

	localparam logic [1:0] FN_SAMPLE = 2'd0;
	localparam logic [1:0] FN_START = 2'd1;
	localparam logic [1:0] FN_STOP = 2'd2;

	localparam logic [15:0] RATE_GAIN_RST = 16'd3901;
	localparam logic [15:0] TIME_STEP_RST = 16'd5243;
	localparam logic [24:0] DEADBAND_RST = 25'd32768;

	localparam int MUL_AW = 34;
	localparam int MUL_BW = 17;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	localparam logic signed [MUL_BW-1:0] K_033 = 17'sd21627;
	localparam logic signed [MUL_BW-1:0] K_07 = 17'sd45875;
	localparam logic signed [MUL_BW-1:0] K_02 = 17'sd13107;
	localparam logic signed [MUL_BW-1:0] K_01 = 17'sd6554;

	localparam int DIV_BPC = 8;
	localparam int MEAN_W = 33;

	typedef logic signed [31:0] word_t;

	function automatic word_t sat32(input logic signed [63:0] v);
		word_t r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/yaw_rate_filter_integrator_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_stall      func, gyro_raw, target_deg
// out      output     out_valid / out_stall    rate_now, rate_filtered, yaw_sum, arrived,
//                                              integrating
// cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A new gyro sample or command is not accepted until the previous one has finished; a command
// goes from idle straight to the done state. Sample processing is set by one shared multiplier
// used six times per sample and by the mean divider, which retires eight quotient bits per cycle.
// The tap line sits in a circular buffer memory; a fill count makes unwritten taps read as zero.
// Reset clears the filter registers and fill count and loads the register defaults; no clearing pass is needed.
// A stalled output word holds the block in its final state; the next word is taken only after.

module yaw_rate_filter_integrator_unit
	import yrfi_pkg::*;
#(
	parameter int TAP_COUNT = TAP_COUNT_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   func,
	input  logic signed [15:0]           gyro_raw,
	input  logic signed [25:0]           target_deg,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [31:0]           rate_now,
	output logic signed [31:0]           rate_filtered,
	output logic signed [31:0]           yaw_sum,
	output logic                         arrived,
	output logic                         integrating,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int LINE_LEN = TAP_COUNT - 1;
	localparam int PTR_W = $clog2(LINE_LEN);
	localparam int FILL_W = $clog2(LINE_LEN + 1);
	localparam int CW = $clog2(TAP_COUNT);
	localparam int TSUM_W = 32 + CW;
	localparam int X_W = 34 + CW;
	localparam int DIV_D = 2 * TAP_COUNT;
	localparam int REM_W = $clog2(DIV_D) + 1;
	localparam int R1_W = REM_W + 1;
	localparam int DIV_ITER = (X_W + DIV_BPC - 1) / DIV_BPC;
	localparam int DIVA_W = DIV_ITER * DIV_BPC;
	localparam int DCNT_W = $clog2(DIV_ITER + 1);
	localparam int UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam logic signed [63:0] RATE_RND = (64'sd1 <<< DN) >>> 1;

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] S_IDLE = 5'd0;
	localparam logic [ST_W-1:0] S_RATE_MUL = 5'd1;
	localparam logic [ST_W-1:0] S_RATE = 5'd2;
	localparam logic [ST_W-1:0] S_REC_MUL = 5'd3;
	localparam logic [ST_W-1:0] S_REC = 5'd4;
	localparam logic [ST_W-1:0] S_SUM = 5'd5;
	localparam logic [ST_W-1:0] S_DIV_LD = 5'd6;
	localparam logic [ST_W-1:0] S_DIV = 5'd7;
	localparam logic [ST_W-1:0] S_MEAN = 5'd8;
	localparam logic [ST_W-1:0] S_BL0 = 5'd9;
	localparam logic [ST_W-1:0] S_BL1 = 5'd10;
	localparam logic [ST_W-1:0] S_BL2 = 5'd11;
	localparam logic [ST_W-1:0] S_BL3 = 5'd12;
	localparam logic [ST_W-1:0] S_FILT = 5'd13;
	localparam logic [ST_W-1:0] S_YAW_MUL = 5'd14;
	localparam logic [ST_W-1:0] S_YAW = 5'd15;
	localparam logic [ST_W-1:0] S_ARR = 5'd16;
	localparam logic [ST_W-1:0] S_DONE = 5'd17;

	logic [ST_W-1:0]             st_q;
	logic                        out_valid_q;

	logic signed [15:0]          offset_q;
	logic [15:0]                 gain_q;
	logic [15:0]                 tstep_q;
	logic [24:0]                 deadband_q;

	word_t                       tap_mem [LINE_LEN];
	word_t                       rd_q;
	logic [PTR_W-1:0]            wptr_q;
	logic [FILL_W-1:0]           fill_q;
	logic signed [TSUM_W-1:0]    tsum_q;
	word_t                       last_q;
	word_t                       rec_q;
	word_t                       h0_q;
	word_t                       h1_q;
	word_t                       yaw_q;
	word_t                       target_q;
	logic                        int_q;
	logic [DCNT_W-1:0]           div_cnt_q;

	logic signed [16:0]          diff_q;
	logic signed [MUL_PW-1:0]    mul_q;
	logic signed [MUL_AW-1:0]    sum1_q;
	logic signed [X_W-1:0]       x_q;
	logic [DIVA_W-1:0]           div_a_q;
	logic [DIVA_W-1:0]           div_quo_q;
	logic [REM_W-1:0]            div_rem_q;
	logic                        div_neg_q;
	logic signed [MEAN_W-1:0]    mean_q;
	logic signed [MUL_PW-1:0]    acc_q;
	logic                        yaw_en_q;
	word_t                       rate_q;
	logic                        arr_q;

	logic signed [MUL_AW-1:0]    mul_a;
	logic signed [MUL_BW-1:0]    mul_b;
	word_t                       rate_c;
	word_t                       oldest_c;
	logic signed [TSUM_W-1:0]    tsum_c;
	logic signed [MUL_AW-1:0]    sum1_c;
	word_t                       rec_c;
	logic signed [X_W-1:0]       x_c;
	logic [DIVA_W-1:0]           a_c;
	logic [REM_W-1:0]            rem_c;
	logic [DIV_BPC-1:0]          qb_c;
	logic signed [MEAN_W-1:0]    mean_c;
	word_t                       filt_c;
	logic [32:0]                 mag_c;
	word_t                       yaw_c;
	logic signed [32:0]          neg_yaw_c;
	logic signed [32:0]          target_ext_c;
	logic                        arr_c;
	logic                        tap_full;
	logic                        out_free;

	assign in_stall = (st_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;
	assign tap_full = (fill_q == FILL_W'(LINE_LEN));
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (st_q)
			S_RATE_MUL: begin
				mul_a = MUL_AW'(diff_q);
				mul_b = $signed({1'b0, gain_q});
			end
			S_REC_MUL: begin
				mul_a = sum1_q;
				mul_b = K_033;
			end
			S_BL0: begin
				mul_a = MUL_AW'(mean_q);
				mul_b = K_07;
			end
			S_BL1: begin
				mul_a = MUL_AW'(h1_q);
				mul_b = K_02;
			end
			S_BL2: begin
				mul_a = MUL_AW'(h0_q);
				mul_b = K_01;
			end
			S_YAW_MUL: begin
				mul_a = MUL_AW'(h1_q);
				mul_b = $signed({1'b0, tstep_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		rate_c = sat32(((64'(mul_q) + RATE_RND) >>> DN) <<< UP);
		oldest_c = tap_full ? rd_q : '0;
		tsum_c = tsum_q + TSUM_W'(rate_c) - TSUM_W'(oldest_c);
		sum1_c = MUL_AW'(rec_q) + MUL_AW'(rate_c) + MUL_AW'(last_q);
		rec_c = sat32((64'(mul_q) + 64'sd32768) >>> 16);
		x_c = ((X_W'(rec_q) + X_W'(tsum_q)) <<< 1) + X_W'(TAP_COUNT);
		if (x_q[X_W-1]) begin
			a_c = DIVA_W'(DIV_D - 1) - DIVA_W'(x_q);
		end else begin
			a_c = DIVA_W'(x_q);
		end
		mean_c = div_neg_q ? -$signed(div_quo_q[MEAN_W-1:0]) : $signed(div_quo_q[MEAN_W-1:0]);
		filt_c = sat32((64'(acc_q) + 64'sd32768) >>> 16);
		mag_c = h1_q[31] ? (33'd0 - 33'(h1_q)) : 33'(h1_q);
		yaw_c = sat32(64'(yaw_q) + ((64'(mul_q) + 64'sd524288) >>> 20));
		neg_yaw_c = 33'sd0 - 33'(yaw_q);
		target_ext_c = 33'(target_q);
		arr_c = (target_q > 32'sd0 && neg_yaw_c > target_ext_c)
			|| (target_q < 32'sd0 && neg_yaw_c < target_ext_c);
	end

	always_comb begin
		logic [REM_W-1:0] rem_v;
		logic [R1_W-1:0] r_v;
		rem_v = div_rem_q;
		qb_c = '0;
		for (int i = 0; i < DIV_BPC; i++) begin
			r_v = {rem_v, div_a_q[DIVA_W-1-i]};
			if (r_v >= R1_W'(DIV_D)) begin
				rem_v = REM_W'(r_v - R1_W'(DIV_D));
				qb_c[DIV_BPC-1-i] = 1'b1;
			end else begin
				rem_v = REM_W'(r_v);
			end
		end
		rem_c = rem_v;
	end

	always_ff @(posedge clk) begin
		rd_q <= tap_mem[wptr_q];
		if (st_q == S_RATE) begin
			tap_mem[wptr_q] <= rate_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid_q <= 1'b0;
			offset_q <= '0;
			gain_q <= RATE_GAIN_RST;
			tstep_q <= TIME_STEP_RST;
			deadband_q <= DEADBAND_RST;
			wptr_q <= '0;
			fill_q <= '0;
			tsum_q <= '0;
			last_q <= '0;
			rec_q <= '0;
			h0_q <= '0;
			h1_q <= '0;
			yaw_q <= '0;
			target_q <= '0;
			int_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_GYRO_OFFSET: offset_q <= cfg_data[15:0];
					CFG_RATE_GAIN: gain_q <= cfg_data[15:0];
					CFG_TIME_STEP: tstep_q <= cfg_data[15:0];
					CFG_DEADBAND: deadband_q <= cfg_data[24:0];
					default: ;
				endcase
			end

			if (st_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						case (func)
							FN_SAMPLE: st_q <= S_RATE_MUL;
							FN_START: begin
								target_q <= 32'(target_deg);
								int_q <= 1'b1;
								st_q <= S_DONE;
							end
							FN_STOP: begin
								yaw_q <= '0;
								int_q <= 1'b0;
								st_q <= S_DONE;
							end
							default: st_q <= S_DONE;
						endcase
					end
				end
				S_RATE_MUL: st_q <= S_RATE;
				S_RATE: begin
					tsum_q <= tsum_c;
					last_q <= rate_c;
					wptr_q <= (wptr_q == PTR_W'(LINE_LEN - 1)) ? '0 : wptr_q + 1'b1;
					if (!tap_full) begin
						fill_q <= fill_q + 1'b1;
					end
					st_q <= S_REC_MUL;
				end
				S_REC_MUL: st_q <= S_REC;
				S_REC: begin
					rec_q <= rec_c;
					st_q <= S_SUM;
				end
				S_SUM: st_q <= S_DIV_LD;
				S_DIV_LD: begin
					div_cnt_q <= DCNT_W'(DIV_ITER);
					st_q <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == DCNT_W'(1)) begin
						st_q <= S_MEAN;
					end
				end
				S_MEAN: st_q <= S_BL0;
				S_BL0: st_q <= S_BL1;
				S_BL1: st_q <= S_BL2;
				S_BL2: st_q <= S_BL3;
				S_BL3: st_q <= S_FILT;
				S_FILT: begin
					h0_q <= h1_q;
					h1_q <= filt_c;
					st_q <= S_YAW_MUL;
				end
				S_YAW_MUL: st_q <= S_YAW;
				S_YAW: begin
					if (yaw_en_q) begin
						yaw_q <= yaw_c;
					end
					st_q <= S_ARR;
				end
				S_ARR: begin
					if (arr_c) begin
						target_q <= '0;
						yaw_q <= '0;
						int_q <= 1'b0;
					end
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		case (st_q)
			S_IDLE: begin
				diff_q <= 17'(gyro_raw) - 17'(offset_q);
				rate_q <= '0;
				arr_q <= 1'b0;
			end
			S_RATE: begin
				rate_q <= rate_c;
				sum1_q <= sum1_c;
			end
			S_SUM: x_q <= x_c;
			S_DIV_LD: begin
				div_a_q <= a_c;
				div_neg_q <= x_q[X_W-1];
				div_rem_q <= '0;
				div_quo_q <= '0;
			end
			S_DIV: begin
				div_a_q <= div_a_q << DIV_BPC;
				div_quo_q <= {div_quo_q[DIVA_W-DIV_BPC-1:0], qb_c};
				div_rem_q <= rem_c;
			end
			S_MEAN: mean_q <= mean_c;
			S_BL1: acc_q <= mul_q;
			S_BL2: acc_q <= acc_q + mul_q;
			S_BL3: acc_q <= acc_q + mul_q;
			S_YAW_MUL: yaw_en_q <= int_q && (mag_c > 33'(deadband_q));
			S_ARR: arr_q <= arr_c;
			S_DONE: begin
				if (out_free) begin
					rate_now <= rate_q;
					rate_filtered <= h1_q;
					yaw_sum <= yaw_q;
					arrived <= arr_q;
					integrating <= int_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(LINE_LEN))
		else $error("tap fill count beyond line length");

	a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!tap_full |-> wptr_q == PTR_W'(fill_q))
		else $error("write pointer out of step with fill count");

	a_arrival_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && arrived |-> !integrating && yaw_sum == 32'sd0)
		else $error("arrival word without cleared yaw and integration");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DIV |-> div_cnt_q != '0)
		else $error("mean divider running with empty count");
`endif

endmodule
